[rtl/cc20_pkg.sv]
// shared constants, types and round functions of the chacha20 stream cipher unit
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

  // state words zero to three
  localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

  localparam int DBL_ROUNDS  = 10;
  // four half quarter rounds per step (one per lane), two halves per round, two rounds per double round
  localparam int ROUND_STEPS = 4 * DBL_ROUNDS;
  localparam int BLOCK_WORDS = 16;
  localparam int STEP_W      = $clog2(ROUND_STEPS);
  localparam int WORD_AW     = $clog2(BLOCK_WORDS);

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_01   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_23   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_45   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_67   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd6;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // first half uses rotations 16 and 12, second half 8 and 7
  function automatic quad_t qr_half(input quad_t q, input logic second);
    quad_t r;
    r.a = q.a + q.b;
    r.d = second ? rotl(q.d ^ r.a, 8) : rotl(q.d ^ r.a, 16);
    r.c = q.c + r.d;
    r.b = second ? rotl(q.b ^ r.c, 7) : rotl(q.b ^ r.c, 12);
    return r;
  endfunction

  // word index of position pos (a..d) in lane, column or diagonal round
  function automatic logic [3:0] lane_idx(input logic diag, input logic [1:0] lane,
                                          input logic [1:0] pos);
    logic [1:0] col;
    col = diag ? 2'(lane + pos) : lane;
    return {pos, col};
  endfunction

endpackage

`default_nettype wire

[rtl/cc20_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module cc20_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/chacha20_stream_cipher_unit.sv]
// chacha20 stream cipher unit: keystream generator, keystream ram and byte xor path
//
// in channel: one byte per item in in_tdata, in_tuser set restarts the run (start
// counter loaded, byte offset zero) before that byte. out channel: the byte xored
// with the keystream plus the block counter of the keystream block used.
// cfg channel: cfg_index selects the register, cfg_data carries the value; always
// ready; a user rule has it only written while the unit is idle, with no check.
// keystream blocks live in a 2 x 16 word ram, one bank read by the byte path and
// one filled by the generator. the generator runs four half quarter rounds a cycle
// through all double rounds and then adds the input state and writes one word a
// cycle into its bank. while bytes of one block flow, the next block (counter plus
// one) is prefetched, so a steady stream runs at one item per cycle as long as the
// receiver keeps out_tready high. the first byte after reset, after a restart to a
// counter that was not prefetched, or after a register write waits for a fresh
// block. an accepted item goes through the ram read stage and then the output
// register before out_tvalid rises.
// at reset the counter and offset are zero, no block is held and generation of
// block zero begins at once. a stalled receiver holds the output register; one more
// item sits in the read stage and then in_tready drops until the output moves.
`timescale 1ns / 1ps
`default_nettype none

module chacha20_stream_cipher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tuser,   // [0] restart
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [7:0] out_byte, [39:8] counter_used
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  // generator states
  localparam logic [1:0] GEN_IDLE  = 2'd0;
  localparam logic [1:0] GEN_ROUND = 2'd1;
  localparam logic [1:0] GEN_FINAL = 2'd2;

  localparam int RAM_DEPTH = 2 * cc20_pkg::BLOCK_WORDS;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // configuration registers
  logic [63:0] key01_r, key23_r, key45_r, key67_r, nonce01_r;
  logic [31:0] nonce2_r, start_ctr_r;

  // stream position
  logic [31:0] block_ctr_r, block_ctr_nxt;
  logic [5:0]  offset_r, offset_nxt;
  logic        cur_bank_r, cur_bank_nxt;

  // prefetched block bookkeeping
  logic        pre_valid_r, pre_valid_nxt;
  logic [31:0] pre_ctr_r, pre_ctr_nxt;

  // generator
  logic [1:0]                           gen_state_r, gen_state_nxt;
  logic [cc20_pkg::STEP_W-1:0]          step_r, step_nxt;
  logic [cc20_pkg::WORD_AW-1:0]         fin_idx_r, fin_idx_nxt;
  logic [31:0]                          gen_ctr_r, gen_ctr_nxt;
  logic [31:0]                          w_r   [cc20_pkg::BLOCK_WORDS];
  logic [31:0]                          w_nxt [cc20_pkg::BLOCK_WORDS];
  logic [31:0]                          w_round [cc20_pkg::BLOCK_WORDS];
  logic [31:0]                          init_w [cc20_pkg::BLOCK_WORDS];
  logic                                 gen_start;
  logic [31:0]                          gen_start_ctr;

  // byte path
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_data_r;
  logic [1:0]  s1_sel_r;
  logic [31:0] s1_ctr_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic [31:0] out_ctr_r;

  logic        in_acc, cfg_acc, s1_go;
  logic [31:0] need_ctr, ahead_ctr;
  logic [5:0]  off_use, off_inc;
  logic        need_blk, pre_hit, gen_busy, demand;
  logic        rd_bank;
  logic [7:0]  ks_byte;

  logic                  ram_we;
  logic [RAM_AW-1:0]     ram_waddr, ram_raddr;
  logic [31:0]           ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid & cfg_ready;

  // a restart byte starts a block at the start counter, otherwise offset zero does
  assign need_ctr  = in_tuser ? start_ctr_r : block_ctr_r;
  assign off_use   = in_tuser ? 6'd0 : offset_r;
  assign need_blk  = (off_use == 6'd0);
  assign off_inc   = off_use + 6'd1;
  assign ahead_ctr = (offset_r == 6'd0) ? block_ctr_r : block_ctr_r + 32'd1;
  assign pre_hit   = pre_valid_r && (pre_ctr_r == need_ctr);
  assign gen_busy  = (gen_state_r != GEN_IDLE);
  assign demand    = in_tvalid && need_blk;

  // room downstream: the read stage is free or moves on this cycle
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = (!need_blk || pre_hit) && (!s1_valid_r || !out_valid_r || out_tready);
  assign in_acc    = in_tvalid & in_tready;

  // a new block swaps in the prefetched bank
  assign rd_bank   = need_blk ? ~cur_bank_r : cur_bank_r;
  assign ram_raddr = {rd_bank, off_use[5:2]};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r     <= '0;
      key23_r     <= '0;
      key45_r     <= '0;
      key67_r     <= '0;
      nonce01_r   <= '0;
      nonce2_r    <= '0;
      start_ctr_r <= '0;
    end else if (cfg_acc) begin
      case (cfg_index)
        cc20_pkg::CFG_KEY_01:   key01_r     <= cfg_data;
        cc20_pkg::CFG_KEY_23:   key23_r     <= cfg_data;
        cc20_pkg::CFG_KEY_45:   key45_r     <= cfg_data;
        cc20_pkg::CFG_KEY_67:   key67_r     <= cfg_data;
        cc20_pkg::CFG_NONCE_01: nonce01_r   <= cfg_data;
        cc20_pkg::CFG_NONCE_2:  nonce2_r    <= cfg_data[31:0];
        cc20_pkg::CFG_START:    start_ctr_r <= cfg_data[31:0];
        default: ;  // unknown index is ignored
      endcase
    end
  end

  // input state of the block: counter comes from the start request or the running job
  always_comb begin
    init_w[0]  = cc20_pkg::SIGMA_0;
    init_w[1]  = cc20_pkg::SIGMA_1;
    init_w[2]  = cc20_pkg::SIGMA_2;
    init_w[3]  = cc20_pkg::SIGMA_3;
    init_w[4]  = key01_r[31:0];
    init_w[5]  = key01_r[63:32];
    init_w[6]  = key23_r[31:0];
    init_w[7]  = key23_r[63:32];
    init_w[8]  = key45_r[31:0];
    init_w[9]  = key45_r[63:32];
    init_w[10] = key67_r[31:0];
    init_w[11] = key67_r[63:32];
    init_w[12] = gen_start ? gen_start_ctr : gen_ctr_r;
    init_w[13] = nonce01_r[31:0];
    init_w[14] = nonce01_r[63:32];
    init_w[15] = nonce2_r;
  end

  // four independent half quarter rounds, column or diagonal
  always_comb begin
    cc20_pkg::quad_t q_in;
    cc20_pkg::quad_t q_out;
    logic            diag;
    diag = step_r[1];
    for (int i = 0; i < cc20_pkg::BLOCK_WORDS; i++) begin
      w_round[i] = w_r[i];
    end
    for (int l = 0; l < 4; l++) begin
      q_in.a = w_r[cc20_pkg::lane_idx(diag, 2'(l), 2'd0)];
      q_in.b = w_r[cc20_pkg::lane_idx(diag, 2'(l), 2'd1)];
      q_in.c = w_r[cc20_pkg::lane_idx(diag, 2'(l), 2'd2)];
      q_in.d = w_r[cc20_pkg::lane_idx(diag, 2'(l), 2'd3)];
      q_out  = cc20_pkg::qr_half(q_in, step_r[0]);
      w_round[cc20_pkg::lane_idx(diag, 2'(l), 2'd0)] = q_out.a;
      w_round[cc20_pkg::lane_idx(diag, 2'(l), 2'd1)] = q_out.b;
      w_round[cc20_pkg::lane_idx(diag, 2'(l), 2'd2)] = q_out.c;
      w_round[cc20_pkg::lane_idx(diag, 2'(l), 2'd3)] = q_out.d;
    end
  end

  // final add: word zero of the shift line plus its input word goes to the ram
  assign ram_we    = (gen_state_r == GEN_FINAL);
  assign ram_waddr = {~cur_bank_r, fin_idx_r};
  assign ram_wdata = w_r[0] + init_w[fin_idx_r];

  // generator and prefetch control
  always_comb begin
    gen_state_nxt = gen_state_r;
    step_nxt      = step_r;
    fin_idx_nxt   = fin_idx_r;
    gen_ctr_nxt   = gen_ctr_r;
    pre_valid_nxt = pre_valid_r;
    pre_ctr_nxt   = pre_ctr_r;
    gen_start     = 1'b0;
    gen_start_ctr = need_ctr;
    for (int i = 0; i < cc20_pkg::BLOCK_WORDS; i++) begin
      w_nxt[i] = w_r[i];
    end

    case (gen_state_r)
      GEN_ROUND: begin
        for (int i = 0; i < cc20_pkg::BLOCK_WORDS; i++) begin
          w_nxt[i] = w_round[i];
        end
        if (step_r == cc20_pkg::STEP_W'(cc20_pkg::ROUND_STEPS - 1)) begin
          gen_state_nxt = GEN_FINAL;
          fin_idx_nxt   = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      GEN_FINAL: begin
        for (int i = 0; i < cc20_pkg::BLOCK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        fin_idx_nxt = fin_idx_r + 1'b1;
        if (fin_idx_r == cc20_pkg::WORD_AW'(cc20_pkg::BLOCK_WORDS - 1)) begin
          gen_state_nxt = GEN_IDLE;
          pre_valid_nxt = 1'b1;
          pre_ctr_nxt   = gen_ctr_r;
        end
      end
      default: ;
    endcase

    // the prefetched bank becomes current
    if (in_acc && need_blk) begin
      pre_valid_nxt = 1'b0;
    end

    if (demand && !pre_hit && !(gen_busy && gen_ctr_r == need_ctr)) begin
      gen_start     = 1'b1;
      gen_start_ctr = need_ctr;
    end else if (!demand && !gen_busy && !pre_valid_r) begin
      gen_start     = 1'b1;
      gen_start_ctr = ahead_ctr;
    end

    if (gen_start) begin
      gen_state_nxt = GEN_ROUND;
      step_nxt      = '0;
      gen_ctr_nxt   = gen_start_ctr;
      pre_valid_nxt = 1'b0;
      for (int i = 0; i < cc20_pkg::BLOCK_WORDS; i++) begin
        w_nxt[i] = init_w[i];
      end
    end

    // any register write: drop the prefetched block and any block under generation
    if (cfg_acc) begin
      gen_state_nxt = GEN_IDLE;
      pre_valid_nxt = 1'b0;
    end
  end

  // stream position
  always_comb begin
    block_ctr_nxt = block_ctr_r;
    offset_nxt    = offset_r;
    cur_bank_nxt  = cur_bank_r;
    if (in_acc) begin
      offset_nxt    = off_inc;
      block_ctr_nxt = (off_inc == 6'd0) ? need_ctr + 32'd1 : need_ctr;
      cur_bank_nxt  = rd_bank;
    end
  end

  // byte path handshakes
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign ks_byte = ram_rdata[{s1_sel_r, 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_ctr_r <= '0;
      offset_r    <= '0;
      cur_bank_r  <= 1'b0;
      pre_valid_r <= 1'b0;
      gen_state_r <= GEN_IDLE;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      block_ctr_r <= block_ctr_nxt;
      offset_r    <= offset_nxt;
      cur_bank_r  <= cur_bank_nxt;
      pre_valid_r <= pre_valid_nxt;
      gen_state_r <= gen_state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pre_ctr_r <= pre_ctr_nxt;
    step_r    <= step_nxt;
    fin_idx_r <= fin_idx_nxt;
    gen_ctr_r <= gen_ctr_nxt;
    for (int i = 0; i < cc20_pkg::BLOCK_WORDS; i++) begin
      w_r[i] <= w_nxt[i];
    end
    if (in_acc) begin
      s1_data_r <= in_tdata;
      s1_sel_r  <= off_use[1:0];
      s1_ctr_r  <= need_ctr;
    end
    if (s1_go) begin
      out_byte_r <= s1_data_r ^ ks_byte;
      out_ctr_r  <= s1_ctr_r;
    end
  end

  // keystream store: bank per block, word per address
  cc20_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_ks_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (in_acc),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ctr_r, out_byte_r};

  // a ready block and a running generator never coexist
  a_pre_vs_gen: assert property (@(posedge clk) disable iff (!rst_n)
    !(pre_valid_r && gen_state_r != GEN_IDLE))
    else $error("prefetched block held while generator busy");

  // a byte that opens a block only goes in when that block is ready
  a_block_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && need_blk) |-> (pre_valid_r && pre_ctr_r == need_ctr))
    else $error("block consumed before it was generated");

  // a finished block carries the counter the generator was started with
  a_done_ctr: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_state_r == GEN_FINAL && $past(gen_state_r) == GEN_FINAL && !$past(gen_start)
     && !$past(cfg_acc)) |-> $stable(gen_ctr_r))
    else $error("generator counter changed during final add");

  // an accepted item reaches the read stage next cycle
  a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item lost before ram read");

endmodule

`default_nettype wire

[dv/tb.sv]
// self-checking testbench for the chacha20 stream cipher unit
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all before giving up
  localparam logic [2:0] CFG_UNUSED = 3'd7;   // no register behind this index

  // "expand 32-byte k", state words zero to three
  localparam logic [31:0] EXPAND_0 = 32'h6170_7865;
  localparam logic [31:0] EXPAND_1 = 32'h3320_646e;
  localparam logic [31:0] EXPAND_2 = 32'h7962_2d32;
  localparam logic [31:0] EXPAND_3 = 32'h6b20_6574;

  typedef struct {
    logic [7:0] text;
    logic       restart;
  } plain_item_t;

  typedef struct {
    logic [7:0]  text;
    logic [31:0] ctr;
  } cipher_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  plain_item_t  pending_bytes[$];
  cipher_item_t expected_out[$];
  bit           in_taken;
  bit           no_gaps;
  int           errors;
  int           quiet_cycles;

  // predictor copy of the registers and the running cipher state
  logic [63:0] key_pair[4];
  logic [63:0] nonce_lo;
  logic [31:0] nonce_hi;
  logic [31:0] start_ctr;
  logic [31:0] blk_ctr;
  logic [5:0]  byte_pos;
  logic [31:0] ks_words[16];

  chacha20_stream_cipher_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one full quarter round on words a, b, c, d
  function automatic logic [127:0] mix4(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    a = a + b; d = rol32(d ^ a, 16);
    c = c + d; b = rol32(b ^ c, 12);
    a = a + b; d = rol32(d ^ a, 8);
    c = c + d; b = rol32(b ^ c, 7);
    return {a, b, c, d};
  endfunction

  // block function: 20 rounds over the current key, counter and nonce, plus feed-forward
  function automatic void refill_keystream();
    logic [31:0] seed[16];
    logic [31:0] w[16];
    seed[0] = EXPAND_0; seed[1] = EXPAND_1; seed[2] = EXPAND_2; seed[3] = EXPAND_3;
    for (int k = 0; k < 4; k++) begin
      seed[4 + 2 * k] = key_pair[k][31:0];
      seed[5 + 2 * k] = key_pair[k][63:32];
    end
    seed[12] = blk_ctr;
    seed[13] = nonce_lo[31:0];
    seed[14] = nonce_lo[63:32];
    seed[15] = nonce_hi;
    w = seed;
    for (int r = 0; r < 10; r++) begin
      {w[0], w[4], w[8],  w[12]} = mix4(w[0], w[4], w[8],  w[12]);
      {w[1], w[5], w[9],  w[13]} = mix4(w[1], w[5], w[9],  w[13]);
      {w[2], w[6], w[10], w[14]} = mix4(w[2], w[6], w[10], w[14]);
      {w[3], w[7], w[11], w[15]} = mix4(w[3], w[7], w[11], w[15]);
      {w[0], w[5], w[10], w[15]} = mix4(w[0], w[5], w[10], w[15]);
      {w[1], w[6], w[11], w[12]} = mix4(w[1], w[6], w[11], w[12]);
      {w[2], w[7], w[8],  w[13]} = mix4(w[2], w[7], w[8],  w[13]);
      {w[3], w[4], w[9],  w[14]} = mix4(w[3], w[4], w[9],  w[14]);
    end
    for (int k = 0; k < 16; k++) ks_words[k] = w[k] + seed[k];
  endfunction

  // xor one byte with the next keystream byte and advance offset and counter
  function automatic cipher_item_t encrypt_byte(input plain_item_t item);
    cipher_item_t res;
    logic [31:0]  word;
    if (item.restart) begin
      blk_ctr  = start_ctr;
      byte_pos = '0;
    end
    if (byte_pos == 0) refill_keystream();
    word     = ks_words[byte_pos[5:2]];
    res.text = item.text ^ word[byte_pos[1:0] * 8 +: 8];
    res.ctr  = blk_ctr;
    byte_pos = byte_pos + 6'd1;
    if (byte_pos == 0) blk_ctr = blk_ctr + 32'd1;
    return res;
  endfunction

  function automatic void set_reg(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      cc20_pkg::CFG_KEY_01:   key_pair[0] = val;
      cc20_pkg::CFG_KEY_23:   key_pair[1] = val;
      cc20_pkg::CFG_KEY_45:   key_pair[2] = val;
      cc20_pkg::CFG_KEY_67:   key_pair[3] = val;
      cc20_pkg::CFG_NONCE_01: nonce_lo = val;
      cc20_pkg::CFG_NONCE_2:  nonce_hi = val[31:0];
      cc20_pkg::CFG_START:    start_ctr = val[31:0];
      default: ;    // unknown index, write has no effect
    endcase
  endfunction

  // sender: a new item goes out once the previous one is taken, with random gaps
  always @(negedge clk) begin
    plain_item_t item;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (pending_bytes.size() != 0 && (no_gaps || $urandom_range(99) >= 9)) begin
        item = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= item.text;
        in_tuser  <= item.restart;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= 9);
  end

  // accepted items feed the predictor, accepted results are checked in order
  always @(posedge clk) begin
    plain_item_t  got_in;
    cipher_item_t want;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      got_in.text    = in_tdata;
      got_in.restart = in_tuser;
      expected_out.push_back(encrypt_byte(got_in));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_out.size() == 0) begin
        $error("result item with none expected: out_byte %h counter_used %h",
               out_tdata[7:0], out_tdata[39:8]);
        errors++;
      end else begin
        want = expected_out.pop_front();
        if (out_tdata[7:0] !== want.text) begin
          $error("out_byte mismatch: expected %h, actual %h", want.text, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[39:8] !== want.ctr) begin
          $error("counter_used mismatch: expected %h, actual %h", want.ctr, out_tdata[39:8]);
          errors++;
        end
      end
    end
    // watchdog on any handshake at all
    if (!rst_n || in_taken || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("chacha20_stream_cipher_unit regression: fail");
      $finish;
    end
  end

  // register write; cfg_valid stays up for back-to-back writes
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, val);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued item is taken and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || expected_out.size() != 0);
  endtask

  task automatic queue_byte(input logic [7:0] text, input logic restart);
    plain_item_t item;
    item.text    = text;
    item.restart = restart;
    pending_bytes.push_back(item);
  endtask

  // random bytes with random restarts, optionally opened by a restart and paused halfway
  task automatic random_run(input int count, input bit lead_restart, input bit mid_pause);
    for (int k = 0; k < count; k++) begin
      if (mid_pause && k == count / 2) drain();
      queue_byte(8'($urandom_range(255)), (k == 0 && lead_restart) || $urandom_range(99) < 2);
    end
    drain();
  endtask

  initial begin
    int phase;
    int sent;
    int count;
    logic [63:0] val;
    for (int k = 0; k < 4; k++) key_pair[k] = '0;
    nonce_lo  = '0;
    nonce_hi  = '0;
    start_ctr = '0;
    blk_ctr   = '0;
    byte_pos  = '0;
    no_gaps   = 1'b0;
    errors    = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: all-zero key straight out of reset, data extremes, restarts
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'haa, 1'b0);
    queue_byte(8'h00, 1'b1);   // restart in the middle of a block
    queue_byte(8'hff, 1'b1);   // two restarts back to back
    queue_byte(8'h7f, 1'b0);
    queue_byte(8'hfe, 1'b0);
    drain();

    // key and nonce change mid-block: the held block must still be used
    write_reg(CFG_UNUSED,             64'hffff_ffff_ffff_ffff);
    write_reg(cc20_pkg::CFG_KEY_01,   64'h0706_0504_0302_0100);
    write_reg(cc20_pkg::CFG_KEY_23,   64'h0f0e_0d0c_0b0a_0908);
    write_reg(cc20_pkg::CFG_KEY_45,   64'h1716_1514_1312_1110);
    write_reg(cc20_pkg::CFG_KEY_67,   64'h1f1e_1d1c_1b1a_1918);
    write_reg(cc20_pkg::CFG_NONCE_01, 64'h4a00_0000_0900_0000);
    write_reg(cc20_pkg::CFG_NONCE_2,  64'h0);
    write_reg(cc20_pkg::CFG_START,    64'h1);
    end_writes();
    for (int k = 0; k < 4; k++) queue_byte(8'($urandom_range(255)), 1'b0);
    queue_byte(8'h00, 1'b1);   // now the new key and counter take over
    for (int k = 0; k < 5; k++) queue_byte(8'($urandom_range(255)), 1'b0);
    drain();

    // all ones everywhere, counter wraps from ffffffff to zero inside the run
    for (int idx = 0; idx < 7; idx++) write_reg(3'(idx), 64'hffff_ffff_ffff_ffff);
    end_writes();
    random_run(150, 1'b1, 1'b0);
    sent = 150;

    // all zero again through the write port
    for (int idx = 0; idx < 7; idx++) write_reg(3'(idx), 64'h0);
    end_writes();
    random_run(90, 1'b1, 1'b0);
    sent += 90;

    // random settings; one phase with no gaps, one with a pause until all results are in
    phase = 0;
    while (sent < 1030) begin
      for (int idx = 0; idx < 8; idx++) begin
        if ($urandom_range(1) == 1) begin
          val = {$urandom, $urandom};
          if (3'(idx) == cc20_pkg::CFG_START) begin
            case ($urandom_range(3))
              0: val = 64'hffff_fffe;
              1: val = 64'h0;
              default: ;
            endcase
          end
          write_reg(3'(idx), val);
        end
      end
      end_writes();
      no_gaps = (phase == 2);
      count = $urandom_range(70, 140);
      random_run(count, $urandom_range(1) == 1, phase == 4);
      no_gaps = 1'b0;
      sent += count;
      phase++;
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("chacha20_stream_cipher_unit regression: pass");
    else
      $display("chacha20_stream_cipher_unit regression: fail");
    $finish;
  end

endmodule

[chacha20_stream_cipher_unit.f]
rtl/cc20_pkg.sv
rtl/cc20_ram.sv
rtl/chacha20_stream_cipher_unit.sv
dv/tb.sv
